@@ src/pfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pfe_pkg: shared types and constants of the playfair digraph encoder
// letter codes, square geometry, register indexes and small helpers
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int LETTER_W = 5;
  localparam int COORD_W  = 3;
  localparam int KW_W     = 50;
  localparam int KLEN_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam int SIDE    = 5;
  localparam int CELLS   = 25;
  localparam int LETTERS = 26;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [COORD_W-1:0]  coord_t;

  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_X = 5'd23;
  localparam letter_t LETTER_Z = 5'd25;
  localparam letter_t LAST_CELL = 5'd24;
  localparam coord_t  LAST_COORD = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_LETTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_LENGTH  = 2'd1;

  // row and column of a letter inside the square
  typedef struct packed {
    coord_t row;
    coord_t col;
  } pos_t;

  // one fill step of the square: cell entry and letter position entry
  typedef struct packed {
    logic    we;
    letter_t cell_idx;
    letter_t letter;
    pos_t    pos;
  } sq_wr_t;

  // saturate to Z and fold J onto I
  function automatic letter_t fold_letter(letter_t v);
    letter_t c;
    c = (v > LETTER_Z) ? LETTER_Z : v;
    if (c == LETTER_J) c = LETTER_I;
    return c;
  endfunction

  // step one place along a row or column with wrap
  function automatic coord_t wrap_inc(coord_t v);
    return (v == LAST_COORD) ? coord_t'(0) : coord_t'(v + coord_t'(1));
  endfunction

  // linear cell index of row r, column c
  function automatic letter_t cell_index(coord_t r, coord_t c);
    return letter_t'({2'b00, r} * letter_t'(SIDE) + {2'b00, c});
  endfunction

endpackage

@@ src/pfe_ram.sv @@
// ----------------------------------------------------------------------------
// pfe_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ src/pfe_builder.sv @@
// ----------------------------------------------------------------------------
// pfe_builder: square fill sequencer
// walks the keyword and then the alphabet, one letter per cycle
// ----------------------------------------------------------------------------
module pfe_builder import pfe_pkg::*; #(
  parameter int KEY_MAX = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KW_W-1:0]   keyword_letters,
  input  logic [KLEN_W-1:0] keyword_length,
  output sq_wr_t            wr,
  output logic              done
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_KEY  = 3'b010,
    B_FILL = 3'b100
  } bstate_t;

  bstate_t           state;
  logic [KW_W-1:0]   kw_shift;
  logic [KLEN_W-1:0] remaining;
  logic [LETTERS-1:0] used;
  letter_t           fill_letter;
  coord_t            n_row;
  coord_t            n_col;
  letter_t           n_idx;

  logic [KLEN_W-1:0] len;
  letter_t           cand;
  logic              take;

  assign len = (keyword_length > KLEN_W'(KEY_MAX)) ? KLEN_W'(KEY_MAX) : keyword_length;

  always_comb begin
    cand = (state == B_KEY) ? fold_letter(kw_shift[LETTER_W-1:0]) : fill_letter;
    take = 1'b0;
    if (state == B_KEY) take = !used[cand];
    else if (state == B_FILL) take = (cand != LETTER_J) && !used[cand];
  end

  assign wr.we       = take;
  assign wr.cell_idx = n_idx;
  assign wr.letter   = cand;
  assign wr.pos      = '{row: n_row, col: n_col};
  assign done        = (state == B_FILL) && take && (n_idx == LAST_CELL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (start) state <= (len == '0) ? B_FILL : B_KEY;
        end
        B_KEY: begin
          if (remaining == KLEN_W'(1)) state <= B_FILL;
        end
        B_FILL: begin
          if (done) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // datapath of the fill walk
  always_ff @(posedge clk) begin
    if (state == B_IDLE) begin
      kw_shift    <= keyword_letters;
      remaining   <= len;
      used        <= '0;
      fill_letter <= '0;
      n_row       <= '0;
      n_col       <= '0;
      n_idx       <= '0;
    end else begin
      if (state == B_KEY) begin
        kw_shift  <= kw_shift >> LETTER_W;
        remaining <= remaining - KLEN_W'(1);
      end else begin
        fill_letter <= fill_letter + letter_t'(1);
      end
      if (take) begin
        used[cand] <= 1'b1;
        n_idx      <= n_idx + letter_t'(1);
        n_col      <= wrap_inc(n_col);
        if (n_col == LAST_COORD) n_row <= n_row + coord_t'(1);
      end
    end
  end

endmodule

@@ src/playfair_digraph_encoder.sv @@
// ----------------------------------------------------------------------------
// playfair_digraph_encoder: playfair cipher encoder over a letter stream
// builds the 5x5 square per message and enciphers digraphs one cell read at a time
// ----------------------------------------------------------------------------
// usage
//   input channel: letter_valid / letter_stall carry plain_letter and message_end
//   output channel: cipher_valid / cipher_stall carry cipher_letter and run_last
//   a beat is taken when valid is high and stall is low
//   the config port writes keyword_letters (index 0) or keyword_length (index 1)
//   with cfg_we; the user must write only while the block is idle, it has no check
// sequence
//   the first letter of a message first fills the square: the keyword walk covers
//   up to KEY_MAX letters and the alphabet walk up to 26 letters
//   each digraph then goes through two position ram reads, one address step,
//   and two square ram reads, the single square read port sets the pace
//   a letter that only waits for its partner is held and starts no digraph
//   results go out through one output register; run_last marks a letter's last one
// reset and stall
//   rst clears the registers, the held letter and the square status; the next
//   letter rebuilds the square. a stalled result holds, and the sequencer waits
//   on the output register before it loads the next result
// ----------------------------------------------------------------------------
module playfair_digraph_encoder import pfe_pkg::*; #(
  parameter int KEY_MAX = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KW_W-1:0]      cfg_data,
  input  logic                 letter_valid,
  output logic                 letter_stall,
  input  logic [4:0]           plain_letter,
  input  logic                 message_end,
  output logic                 cipher_valid,
  input  logic                 cipher_stall,
  output logic [4:0]           cipher_letter,
  output logic                 run_last
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_BUILD = 8'b0000_0010,
    S_POSA  = 8'b0000_0100,
    S_POSB  = 8'b0000_1000,
    S_ADDR  = 8'b0001_0000,
    S_RD1   = 8'b0010_0000,
    S_LD1   = 8'b0100_0000,
    S_LD2   = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [KW_W-1:0]   keyword_letters;
  logic [KLEN_W-1:0] keyword_length;

  // message state
  letter_t held_letter;
  logic    held_valid;
  logic    square_ready;

  // current digraph
  letter_t pair_a;
  letter_t pair_b;
  logic    has_pair;
  logic    more_pairs;
  pos_t    pos_a;
  letter_t addr1;
  letter_t addr2;

  // accept decode
  logic    accept;
  letter_t p;
  letter_t pa_next;
  letter_t pb_next;
  logic    has_next;
  logic    two_next;

  // builder and rams
  logic   build_start;
  logic   build_done;
  sq_wr_t wr;
  pos_t   pos_rdata;
  letter_t sq_rdata;
  logic   pos_re;
  letter_t pos_raddr;
  logic   sq_re;
  letter_t sq_raddr;

  // output register
  logic slot_free;
  logic load_out;

  assign letter_stall = (state != S_IDLE);
  assign accept       = letter_valid && !letter_stall;
  assign slot_free    = !cipher_valid || !cipher_stall;

  // config writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      keyword_letters <= '0;
      keyword_length  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEYWORD_LETTERS: keyword_letters <= cfg_data;
        CFG_KEYWORD_LENGTH:  keyword_length  <= cfg_data[KLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // pairing rules for the incoming letter
  always_comb begin
    p        = fold_letter(plain_letter);
    pa_next  = p;
    pb_next  = LETTER_X;
    has_next = 1'b0;
    two_next = 1'b0;
    if (!held_valid) begin
      // lone last letter pairs with x
      has_next = message_end;
    end else if (held_letter == p) begin
      // doubled letter: first one pairs with x, at message end the second too
      pa_next  = held_letter;
      has_next = 1'b1;
      two_next = message_end;
    end else begin
      pa_next  = held_letter;
      pb_next  = p;
      has_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_letter  <= '0;
      held_valid   <= 1'b0;
      square_ready <= 1'b0;
    end else if (accept) begin
      square_ready <= !message_end;
      if (message_end) begin
        held_valid  <= 1'b0;
        held_letter <= '0;
      end else if (!held_valid) begin
        held_letter <= p;
        held_valid  <= 1'b1;
      end else if (held_letter != p) begin
        held_valid <= 1'b0;
      end
    end
  end

  assign build_start = accept && !square_ready;

  pfe_builder #(
    .KEY_MAX(KEY_MAX)
  ) u_builder (
    .clk             (clk),
    .rst             (rst),
    .start           (build_start),
    .keyword_letters (keyword_letters),
    .keyword_length  (keyword_length),
    .wr              (wr),
    .done            (build_done)
  );

  // letter -> position table
  pfe_ram #(
    .WIDTH($bits(pos_t)),
    .DEPTH(LETTERS)
  ) u_pos_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.letter),
    .wdata (wr.pos),
    .re    (pos_re),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  // cell -> letter table
  pfe_ram #(
    .WIDTH(LETTER_W),
    .DEPTH(CELLS)
  ) u_sq_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.cell_idx),
    .wdata (wr.letter),
    .re    (sq_re),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  assign pos_re    = (state == S_POSA) || (state == S_POSB);
  assign pos_raddr = (state == S_POSA) ? pair_a : pair_b;
  // second cell read goes out as the first result is loaded
  assign sq_re     = (state == S_RD1) || ((state == S_LD1) && slot_free);
  assign sq_raddr  = (state == S_RD1) ? addr1 : addr2;
  assign load_out  = ((state == S_LD1) || (state == S_LD2)) && slot_free;

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!square_ready) state <= S_BUILD;
            else if (has_next) state <= S_POSA;
          end
        end
        S_BUILD: begin
          if (build_done) state <= has_pair ? S_POSA : S_IDLE;
        end
        S_POSA: state <= S_POSB;
        S_POSB: state <= S_ADDR;
        S_ADDR: state <= S_RD1;
        S_RD1:  state <= S_LD1;
        S_LD1: begin
          if (slot_free) state <= S_LD2;
        end
        S_LD2: begin
          if (slot_free) state <= more_pairs ? S_POSA : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // digraph datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      pair_a     <= pa_next;
      pair_b     <= pb_next;
      has_pair   <= has_next;
      more_pairs <= two_next;
    end else if ((state == S_LD2) && slot_free) begin
      more_pairs <= 1'b0;
    end
    if (state == S_POSB) pos_a <= pos_rdata;
    if (state == S_ADDR) begin
      if (pos_a.row == pos_rdata.row) begin
        // same row: shift right
        addr1 <= cell_index(pos_a.row, wrap_inc(pos_a.col));
        addr2 <= cell_index(pos_rdata.row, wrap_inc(pos_rdata.col));
      end else if (pos_a.col == pos_rdata.col) begin
        // same column: shift down
        addr1 <= cell_index(wrap_inc(pos_a.row), pos_a.col);
        addr2 <= cell_index(wrap_inc(pos_rdata.row), pos_rdata.col);
      end else begin
        // rectangle: swap columns
        addr1 <= cell_index(pos_a.row, pos_rdata.col);
        addr2 <= cell_index(pos_rdata.row, pos_a.col);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_valid <= 1'b0;
    end else if (load_out) begin
      cipher_valid <= 1'b1;
    end else if (!cipher_stall) begin
      cipher_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      cipher_letter <= sq_rdata;
      run_last      <= (state == S_LD2) && !more_pairs;
    end
  end

`ifndef SYNTHESIS
  // builder only writes the tables while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst) wr.we |-> state == S_BUILD)
    else $error("square written outside build");

  // a first letter of a message always starts a build
  assert property (@(posedge clk) disable iff (rst)
    (accept && !square_ready) |=> state == S_BUILD)
    else $error("square not rebuilt");

  // loading the second result of a digraph always presents a beat
  assert property (@(posedge clk) disable iff (rst)
    (state == S_LD2 && slot_free) |=> cipher_valid)
    else $error("result lost");

  // a beat marked last only leaves the final load of an item
  assert property (@(posedge clk) disable iff (rst)
    (load_out && state == S_LD1) |=> !run_last)
    else $error("first result of a digraph marked last");
`endif

endmodule

@@ test/playfair_digraph_encoder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_encoder_checker: scoreboard for the playfair encoder
// mirrors register writes and letter beats, rebuilds the square on its own,
// predicts cipher beats and compares them in order with the output channel
// ----------------------------------------------------------------------------
module playfair_digraph_encoder_checker import pfe_pkg::*; #(
  parameter int KEY_MAX = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KW_W-1:0]      cfg_data,
  input  logic                 letter_valid,
  input  logic                 letter_stall,
  input  logic [4:0]           plain_letter,
  input  logic                 message_end,
  input  logic                 cipher_valid,
  input  logic                 cipher_stall,
  input  logic [4:0]           cipher_letter,
  input  logic                 run_last,
  output int                   mismatch_count,
  output int                   cipher_backlog
);

  localparam letter_t LETTER_A = 5'd0;
  localparam int MAX_PRINTED = 200;

  typedef struct packed {
    letter_t letter;
    logic    last;
  } cipher_beat_t;

  cipher_beat_t    expected_cipher[$];
  logic [KW_W-1:0] keyword_reg;
  logic [KLEN_W-1:0] keylen_reg;
  letter_t         square[CELLS];
  int              row_of[LETTERS];
  int              col_of[LETTERS];
  letter_t         held_letter;
  logic            held_ok;
  logic            square_built;
  int              mismatches = 0;

  assign mismatch_count = mismatches;

  // codes above Z saturate, J shares the cell of I
  function automatic letter_t fold_plain(letter_t v);
    if (v == LETTER_J) return LETTER_I;
    if (v > LETTER_Z) return LETTER_Z;
    return v;
  endfunction

  function automatic void fill_square();
    logic    used[LETTERS];
    int      n;
    int      klen;
    letter_t c;
    foreach (used[k]) used[k] = 1'b0;
    n = 0;
    klen = (keylen_reg > KEY_MAX) ? KEY_MAX : int'(keylen_reg);
    for (int i = 0; i < klen; i++) begin
      c = (5 * i + 5 <= KW_W) ? fold_plain(keyword_reg[5*i +: 5]) : LETTER_A;
      if (!used[c] && n < CELLS) begin
        used[c] = 1'b1;
        square[n] = c;
        n++;
      end
    end
    for (int i = 0; i < LETTERS && n < CELLS; i++) begin
      if (i != LETTER_J && !used[i]) begin
        used[i] = 1'b1;
        square[n] = letter_t'(i);
        n++;
      end
    end
    for (int i = 0; i < CELLS; i++) begin
      row_of[square[i]] = i / SIDE;
      col_of[square[i]] = i % SIDE;
    end
    row_of[LETTER_J] = row_of[LETTER_I];
    col_of[LETTER_J] = col_of[LETTER_I];
    square_built = 1'b1;
  endfunction

  function automatic void push_digraph(letter_t a, letter_t b);
    int           ra, ca, rb, cb;
    cipher_beat_t first, second;
    ra = row_of[a];
    ca = col_of[a];
    rb = row_of[b];
    cb = col_of[b];
    first.last = 1'b0;
    second.last = 1'b0;
    if (ra == rb) begin
      first.letter  = square[ra * SIDE + (ca + 1) % SIDE];
      second.letter = square[rb * SIDE + (cb + 1) % SIDE];
    end else if (ca == cb) begin
      first.letter  = square[((ra + 1) % SIDE) * SIDE + ca];
      second.letter = square[((rb + 1) % SIDE) * SIDE + cb];
    end else begin
      first.letter  = square[ra * SIDE + cb];
      second.letter = square[rb * SIDE + ca];
    end
    expected_cipher.push_back(first);
    expected_cipher.push_back(second);
  endfunction

  function automatic void predict_letter(letter_t raw, logic fin);
    letter_t      p;
    int           size_before;
    cipher_beat_t tail;
    p = fold_plain(raw);
    size_before = expected_cipher.size();
    if (!square_built) fill_square();
    if (!held_ok) begin
      if (fin) push_digraph(p, LETTER_X);
      else begin
        held_letter = p;
        held_ok = 1'b1;
      end
    end else if (held_letter == p) begin
      push_digraph(held_letter, LETTER_X);
      if (fin) begin
        push_digraph(p, LETTER_X);
        held_ok = 1'b0;
      end
    end else begin
      push_digraph(held_letter, p);
      held_ok = 1'b0;
    end
    if (fin) begin
      held_ok = 1'b0;
      held_letter = LETTER_A;
      square_built = 1'b0;
    end
    if (expected_cipher.size() > size_before) begin
      tail = expected_cipher.pop_back();
      tail.last = 1'b1;
      expected_cipher.push_back(tail);
    end
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTED) $display("%0t ns  mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cipher_beat_t want;
    if (rst) begin
      keyword_reg = '0;
      keylen_reg = '0;
      held_letter = LETTER_A;
      held_ok = 1'b0;
      square_built = 1'b0;
      expected_cipher.delete();
    end else begin
      if (cipher_valid && !cipher_stall) begin
        if (expected_cipher.size() == 0) begin
          report_mismatch($sformatf("cipher beat %0d last %0d with nothing expected",
                                    cipher_letter, run_last));
        end else begin
          want = expected_cipher.pop_front();
          if (cipher_letter !== want.letter)
            report_mismatch($sformatf("cipher_letter %0d, expected %0d",
                                      cipher_letter, want.letter));
          if (run_last !== want.last)
            report_mismatch($sformatf("run_last %0d, expected %0d", run_last, want.last));
        end
      end
      if (letter_valid && !letter_stall) predict_letter(plain_letter, message_end);
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEYWORD_LETTERS: keyword_reg = cfg_data;
          CFG_KEYWORD_LENGTH:  keylen_reg = cfg_data[KLEN_W-1:0];
          default: ;
        endcase
      end
    end
    cipher_backlog <= expected_cipher.size();
  end

endmodule

@@ test/playfair_digraph_encoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_encoder_tb: top testbench of the playfair digraph encoder
// drives register settings and letter streams with random gaps and stalls,
// the checker beside the block predicts every cipher beat and counts errors
// ----------------------------------------------------------------------------
module playfair_digraph_encoder_tb import pfe_pkg::*; ();

  localparam int KEY_MAX       = 10;
  localparam int SETTLE_CYCLES = 64;    // square build plus one digraph, with margin
  localparam int PHASES        = 10;
  localparam int PHASE_LETTERS = 29;    // random letters per register setting
  localparam int DIRECTED_N    = 21;

  // register slots past the two real ones, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // directed letters as {message_end, letter}, square is the bare alphabet
  localparam logic [5:0] DIRECTED [DIRECTED_N] = '{
    6'd0,  6'd1,              // A B: same row
    6'd0,  6'd5,              // A F: same column
    6'd0,  6'd6,              // A G: rectangle
    6'd11, 6'd11, 6'd10,      // L L K: doubled letter padded with X
    6'd9,  6'd10,             // J K: J folds onto I
    6'd31, 6'd0,              // code above Z saturates
    6'd23, 6'd23, 6'd24,      // X X: padded pair stays in its row
    6'd12, 6'd44,             // M M at message end: four beats
    6'd45,                    // N alone: lone last letter
    6'd25, 6'd62              // Z then saturated Z at message end
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [KW_W-1:0]      cfg_data;
  logic                 letter_valid;
  logic                 letter_stall;
  logic [4:0]           plain_letter;
  logic                 message_end;
  logic                 cipher_valid;
  logic                 cipher_stall;
  logic [4:0]           cipher_letter;
  logic                 run_last;
  int                   mismatch_count;
  int                   cipher_backlog;
  logic                 steady_flow;    // no gaps and no stalls in this phase

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  playfair_digraph_encoder #(.KEY_MAX(KEY_MAX)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .letter_valid  (letter_valid),
    .letter_stall  (letter_stall),
    .plain_letter  (plain_letter),
    .message_end   (message_end),
    .cipher_valid  (cipher_valid),
    .cipher_stall  (cipher_stall),
    .cipher_letter (cipher_letter),
    .run_last      (run_last)
  );

  playfair_digraph_encoder_checker #(.KEY_MAX(KEY_MAX)) i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .letter_valid   (letter_valid),
    .letter_stall   (letter_stall),
    .plain_letter   (plain_letter),
    .message_end    (message_end),
    .cipher_valid   (cipher_valid),
    .cipher_stall   (cipher_stall),
    .cipher_letter  (cipher_letter),
    .run_last       (run_last),
    .mismatch_count (mismatch_count),
    .cipher_backlog (cipher_backlog)
  );

  // hard stop: ends a run that hangs
  initial begin
    #5_000_000;
    $display("playfair_digraph_encoder_tb NOT OK");
    $finish;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // receiver backpressure, runs on its own and ignores cipher_valid
  initial begin
    int hold;
    hold = 0;
    cipher_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) hold--;
      else if (steady_flow || $urandom_range(99) >= 30) begin
        cipher_stall <= 1'b0;
        hold = $urandom_range(6, 1);
      end else begin
        cipher_stall <= 1'b1;
        hold = pick_gap() + 1;
      end
    end
  end

  // one letter beat, held until the block takes it
  task automatic send_letter(letter_t letter, logic fin);
    int gap;
    gap = steady_flow ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      letter_valid <= 1'b0;
    end
    @(negedge clk);
    letter_valid <= 1'b1;
    plain_letter <= letter;
    message_end  <= fin;
    do @(posedge clk); while (letter_stall);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [KW_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // stop sending, let every predicted beat drain, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    letter_valid <= 1'b0;
    while (cipher_backlog != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [KW_W-1:0] random_wide();
    return KW_W'({$urandom, $urandom});
  endfunction

  // random letters with a bias toward doubles, X, J and saturated codes;
  // the last beat usually ends the message, otherwise the next register
  // write lands in the middle of one
  task automatic run_random_phase(int count);
    letter_t letter;
    letter_t prev;
    logic    fin;
    int      r;
    prev = '0;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 20) letter = prev;
      else if (r < 30) letter = LETTER_X;
      else if (r < 38) letter = letter_t'($urandom_range(31, 26));
      else if (r < 45) letter = LETTER_J;
      else letter = letter_t'($urandom_range(25, 0));
      if (i == count - 1) fin = ($urandom_range(3) != 0);
      else fin = ($urandom_range(8) == 0);
      send_letter(letter, fin);
      prev = letter;
    end
  endtask

  initial begin
    logic [KW_W-1:0]   keyword;
    logic [KLEN_W-1:0] keylen;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    letter_valid = 1'b0;
    plain_letter = '0;
    message_end  = 1'b0;
    steady_flow  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed beats with registers at their reset values
    foreach (DIRECTED[k]) send_letter(DIRECTED[k][4:0], DIRECTED[k][5]);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin                  // all ones: every letter saturates, length clamps
          keyword = '1;
          keylen  = '1;
        end
        1: begin                  // all A keyword of full length
          keyword = '0;
          keylen  = KLEN_W'(KEY_MAX);
        end
        2: begin                  // alternating J and I collapse to one letter
          for (int i = 0; i < KEY_MAX; i++)
            keyword[5*i +: 5] = (i % 2) ? LETTER_I : LETTER_J;
          keylen = KLEN_W'(KEY_MAX);
        end
        3: begin                  // zero length ignores the letters
          keyword = random_wide();
          keylen  = '0;
        end
        4: begin                  // one letter past the limit
          keyword = random_wide();
          keylen  = KLEN_W'(KEY_MAX + 1);
        end
        default: begin
          keyword = random_wide();
          keylen  = KLEN_W'($urandom_range(15));
        end
      endcase
      write_reg(CFG_KEYWORD_LETTERS, keyword);
      // upper data bits are junk for the length register
      write_reg(CFG_KEYWORD_LENGTH, (random_wide() << KLEN_W) | KW_W'(keylen));
      if (p % 3 == 1) write_reg(CFG_SPARE_LO, random_wide());
      if (p % 3 == 2) write_reg(CFG_SPARE_HI, random_wide());
      steady_flow = (p % 4 == 2);
      run_random_phase(PHASE_LETTERS);
      wait_drained();
    end

    if (mismatch_count == 0) $display("playfair_digraph_encoder_tb OK");
    else $display("playfair_digraph_encoder_tb NOT OK");
    $finish;
  end

endmodule
